// File: src/hpq_pkg.sv
// Package for the heap priority queue engine.
// Holds sizes, command and status codes and the entry type. Depends on nothing.
`default_nettype none
package hpq_pkg;
    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_POLL     = 3'd1;
    localparam logic [2:0] CMD_PEEK     = 3'd2;
    localparam logic [2:0] CMD_CONTAINS = 3'd3;
    localparam logic [2:0] CMD_REMOVE   = 3'd4;
    localparam logic [2:0] CMD_MODIFY   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } t_entry;
endpackage
`default_nettype wire

// File: src/hpq_cmd_if.sv
// Command channel of the heap priority queue engine.
// Depends on hpq_pkg.
`default_nettype none
interface hpq_cmd_if;
    import hpq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           cmd;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
    logic [KEY_BITS-1:0]  new_key;
    modport source(output valid, cmd, key, payload, new_key, input ready);
    modport sink(input valid, cmd, key, payload, new_key, output ready);
endinterface
`default_nettype wire

// File: src/hpq_res_if.sv
// Result channel of the heap priority queue engine.
// Depends on hpq_pkg.
`default_nettype none
interface hpq_res_if;
    import hpq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [KEY_BITS-1:0]  out_key;
    logic [DATA_BITS-1:0] out_payload;
    logic [CNT_W-1:0]     entry_count;
    modport source(output valid, status, out_key, out_payload, entry_count, input ready);
    modport sink(input valid, status, out_key, out_payload, entry_count, output ready);
endinterface
`default_nettype wire

// File: src/hpq_cfg_if.sv
// Configuration write channel: carries the queue order bit.
// Depends on nothing.
`default_nettype none
interface hpq_cfg_if;
    logic valid;
    logic ready;
    logic queue_order;
    modport source(output valid, queue_order, input ready);
    modport sink(input valid, queue_order, output ready);
endinterface
`default_nettype wire

// File: src/hpq_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on hpq_pkg.
`default_nettype none
module hpq_ram (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [hpq_pkg::IDX_W-1:0] i_waddr,
    input  wire hpq_pkg::t_entry       i_wdata,
    input  wire logic [hpq_pkg::IDX_W-1:0] i_raddr,
    output      hpq_pkg::t_entry       o_rdata
);
    import hpq_pkg::*;

    t_entry mem [CAPACITY];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/heap_priority_queue_engine.sv
// Binary heap priority queue of key/data words, min or max order by the config bit.
// One command runs at a time through an entry RAM with one write and one read port.
// Insert sifts the new entry up level by level; poll moves the last entry to the root and
// sifts it down; peek reads the root; contains, remove and modify first scan every stored
// entry for the key, then remove and modify sift the moved entry; each command ends by posting
// a result word. The config bit is written only between commands.
// Depends on hpq_pkg, the channel interfaces and hpq_ram.
`default_nettype none
module heap_priority_queue_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hpq_cmd_if.sink   i_cmd,
    hpq_cfg_if.sink   i_cfg,
    hpq_res_if.source o_res
);
    import hpq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TOP    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_UP     = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_DN     = 4'd6;
    localparam logic [3:0] S_DN_L   = 4'd7;
    localparam logic [3:0] S_DN_R   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    function automatic logic beats(input logic ord, input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
        return ord ? (a > b) : (a < b);
    endfunction

    // control registers
    logic [3:0]       r_state, n_state;
    logic             r_order, n_order;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic             r_ov, n_ov;
    logic             r_down, n_down;
    logic             r_pv, n_pv;
    logic             r_hit, n_hit;
    // payload registers
    logic [2:0]          r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_nkey, n_nkey;
    t_entry              r_cur, n_cur;
    t_entry              r_best, n_best;
    logic                r_bsel, n_bsel;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_bidx, n_bidx;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_pi, n_pi;
    logic [IDX_W-1:0]    r_at, n_at;
    logic [1:0]          r_st, n_st;
    logic [KEY_BITS-1:0] r_okey, n_okey;
    logic [DATA_BITS-1:0] r_odata, n_odata;
    logic [1:0]           r_o_st, n_o_st;
    logic [KEY_BITS-1:0]  r_o_key, n_o_key;
    logic [DATA_BITS-1:0] r_o_data, n_o_data;
    logic [CNT_W-1:0]     r_o_cnt, n_o_cnt;

    // RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           rd;

    // helpers
    logic [CNT_W-1:0] occ_dec;
    logic [IDX_W-1:0] par;
    logic [IDX_W:0]   lc;
    logic [IDX_W:0]   rc;
    logic             cmd_acc;

    hpq_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_st;
    assign o_res.out_key     = r_o_key;
    assign o_res.out_payload = r_o_data;
    assign o_res.entry_count = r_o_cnt;

    assign cmd_acc = i_cmd.valid && (r_state == S_IDLE);
    assign occ_dec = r_occ - CNT_W'(1);
    assign par     = (r_idx - IDX_W'(1)) >> 1;
    assign lc      = {r_idx, 1'b1};
    assign rc      = lc + (IDX_W+1)'(1);

    // sequencer
    always_comb begin
        n_state = r_state; n_order = r_order; n_occ = r_occ; n_ov = r_ov;
        n_down = r_down; n_pv = r_pv; n_hit = r_hit;
        n_cmd = r_cmd; n_key = r_key; n_nkey = r_nkey; n_cur = r_cur;
        n_best = r_best; n_bsel = r_bsel; n_idx = r_idx; n_bidx = r_bidx;
        n_i = r_i; n_pi = r_pi; n_at = r_at; n_st = r_st;
        n_okey = r_okey; n_odata = r_odata;
        n_o_st = r_o_st; n_o_key = r_o_key; n_o_data = r_o_data; n_o_cnt = r_o_cnt;
        ram_we = 1'b0; ram_waddr = r_idx; ram_wdata = r_cur; ram_raddr = '0;

        // drop the result word once taken
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg.valid) begin
                    n_order = i_cfg.queue_order;
                end
                if (cmd_acc) begin
                    n_cmd = i_cmd.cmd; n_key = i_cmd.key; n_nkey = i_cmd.new_key;
                    n_st = ST_OK; n_okey = '0; n_odata = '0;
                    n_i = '0; n_pv = 1'b0; n_hit = 1'b0; n_down = 1'b0;
                    n_state = S_OUT;
                    case (i_cmd.cmd)
                        CMD_INSERT: begin
                            if (r_occ == CNT_W'(CAPACITY)) begin
                                n_st = ST_FULL;
                            end else begin
                                n_cur   = '{key: i_cmd.key, data: i_cmd.payload};
                                n_idx   = r_occ[IDX_W-1:0];
                                n_occ   = r_occ + CNT_W'(1);
                                n_state = S_UP;
                            end
                        end
                        CMD_POLL, CMD_PEEK: begin
                            if (r_occ == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                ram_raddr = '0;
                                n_state   = S_TOP;
                            end
                        end
                        CMD_CONTAINS: begin
                            n_state = S_SCAN;
                        end
                        CMD_REMOVE, CMD_MODIFY: begin
                            if (r_occ == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_st = ST_OK;
                        end
                    endcase
                end
            end
            S_TOP: begin
                n_okey  = rd.key;
                n_odata = rd.data;
                n_state = S_OUT;
                if (r_cmd == CMD_POLL) begin
                    n_occ = occ_dec;
                    if (occ_dec != '0) begin
                        ram_raddr = occ_dec[IDX_W-1:0];
                        n_idx     = '0;
                        n_state   = S_LOAD;
                    end
                end
            end
            S_SCAN: begin
                // compare the word read last cycle, keep the last match
                if (r_pv && rd.key == r_key) begin
                    n_hit = 1'b1;
                    n_at  = r_pi;
                end
                if (r_i < r_occ) begin
                    ram_raddr = r_i[IDX_W-1:0];
                    n_pi = r_i[IDX_W-1:0];
                    n_pv = 1'b1;
                    n_i  = r_i + CNT_W'(1);
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_OUT;
                        if (!r_hit) begin
                            n_st = ST_NOT_FOUND;
                        end else begin
                            case (r_cmd)
                                CMD_REMOVE: begin
                                    n_occ = occ_dec;
                                    if (CNT_W'(r_at) < occ_dec) begin
                                        ram_raddr = occ_dec[IDX_W-1:0];
                                        n_idx     = r_at;
                                        n_down    = 1'b1;
                                        n_state   = S_LOAD;
                                    end
                                end
                                CMD_MODIFY: begin
                                    ram_raddr = r_at;
                                    n_idx     = r_at;
                                    n_state   = S_LOAD;
                                end
                                default: begin
                                    n_st = ST_OK;
                                end
                            endcase
                        end
                    end
                end
            end
            S_LOAD: begin
                case (r_cmd)
                    CMD_MODIFY: begin
                        n_cur = '{key: r_nkey, data: rd.data};
                        if ((r_key < r_nkey) ? r_order : !r_order) begin
                            n_state = S_UP;
                        end else begin
                            n_state = S_DN;
                        end
                    end
                    CMD_REMOVE: begin
                        n_cur   = rd;
                        n_state = S_UP;
                    end
                    default: begin
                        n_cur   = rd;
                        n_state = S_DN;
                    end
                endcase
            end
            S_UP: begin
                if (r_idx == '0 || CNT_W'(r_idx) >= r_occ) begin
                    if (r_down) begin
                        n_down  = 1'b0;
                        n_state = S_DN;
                    end else begin
                        ram_we  = 1'b1;
                        n_state = S_OUT;
                    end
                end else begin
                    ram_raddr = par;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (beats(r_order, r_cur.key, rd.key)) begin
                    // move the parent down into the hole
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                    n_idx     = par;
                    n_state   = S_UP;
                end else if (r_down) begin
                    n_down  = 1'b0;
                    n_state = S_DN;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DN: begin
                if (lc >= (IDX_W+1)'(r_occ)) begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    ram_raddr = lc[IDX_W-1:0];
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                if (beats(r_order, rd.key, r_cur.key)) begin
                    n_best = rd; n_bidx = lc[IDX_W-1:0]; n_bsel = 1'b1;
                end else begin
                    n_best = r_cur; n_bidx = r_idx; n_bsel = 1'b0;
                end
                if (rc < (IDX_W+1)'(r_occ)) begin
                    ram_raddr = rc[IDX_W-1:0];
                    n_state   = S_DN_R;
                end else if (n_bsel) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                    n_idx     = lc[IDX_W-1:0];
                    n_state   = S_DN;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DN_R: begin
                if (beats(r_order, rd.key, r_best.key)) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                    n_idx     = rc[IDX_W-1:0];
                    n_state   = S_DN;
                end else if (r_bsel) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_best;
                    n_idx     = r_bidx;
                    n_state   = S_DN;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // post the result word once the output register is free
                if (!r_ov || o_res.ready) begin
                    n_ov     = 1'b1;
                    n_o_st   = r_st;
                    n_o_key  = r_okey;
                    n_o_data = r_odata;
                    n_o_cnt  = r_occ;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_order <= 1'b0; r_occ <= '0; r_ov <= 1'b0;
            r_down <= 1'b0; r_pv <= 1'b0; r_hit <= 1'b0;
        end else begin
            r_state <= n_state; r_order <= n_order; r_occ <= n_occ; r_ov <= n_ov;
            r_down <= n_down; r_pv <= n_pv; r_hit <= n_hit;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_key <= n_key; r_nkey <= n_nkey; r_cur <= n_cur;
        r_best <= n_best; r_bsel <= n_bsel; r_idx <= n_idx; r_bidx <= n_bidx;
        r_i <= n_i; r_pi <= n_pi; r_at <= n_at; r_st <= n_st;
        r_okey <= n_okey; r_odata <= n_odata;
        r_o_st <= n_o_st; r_o_key <= n_o_key; r_o_data <= n_o_data; r_o_cnt <= n_o_cnt;
    end

    // checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + CNT_W'(1))
        || (r_occ == $past(r_occ) - CNT_W'(1)))
        else $error("occupancy moved by more than one");
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state != S_IDLE))
        else $error("command accepted without work");
    a_scan_idle_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_i <= r_occ))
        else $error("scan ran past occupancy");
endmodule
`default_nettype wire
